@@ hdl/wbf_pkg.sv @@
// shared types, constants and tap arithmetic for the weighted window blur filter
`default_nettype none

package wbf_pkg;

  // field widths
  localparam int IMAGE_SIZE_W = 10;
  localparam int CHAN_W       = 16;
  localparam int CHAN_N       = 3;
  localparam int PIX_W        = CHAN_W * CHAN_N;

  // configuration defaults
  localparam int MAX_SIZE_DEFAULT = 512;
  localparam int IMAGE_SIZE_RESET = 32;

  // input kind carried on tuser
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // window taps, named by (row offset, column offset) from the result position
  localparam int TAP_N  = 7;
  localparam int TAP_00 = 0;
  localparam int TAP_01 = 1;
  localparam int TAP_10 = 2;
  localparam int TAP_11 = 3;
  localparam int TAP_12 = 4;
  localparam int TAP_21 = 5;
  localparam int TAP_22 = 6;

  // tap weights in hundredths
  localparam int WEIGHT_W = 7;
  localparam logic [WEIGHT_W-1:0] TAP_WEIGHT [TAP_N] = '{
    7'd60, 7'd3, 7'd3, 7'd30, 7'd3, 7'd3, 7'd10
  };

  // floor(x / 100) as (x * DIV_RECIP) >> DIV_SHIFT, exact for x below 2^22
  localparam int DIV_SHIFT = 29;
  localparam int DIV_RECIP = 5368710;
  localparam int PROD_W    = CHAN_W + DIV_SHIFT;

  typedef logic [PIX_W-1:0]  pixel_t;
  typedef logic [CHAN_W-1:0] chan_t;
  typedef pixel_t [TAP_N-1:0] tap_vec_t;

  // floor(chan * k / 100) with one constant multiply
  function automatic chan_t tap_scale(input chan_t chan, input logic [WEIGHT_W-1:0] k);
    logic [PROD_W-1:0] factor;
    logic [PROD_W-1:0] prod;
    factor = PROD_W'(k) * PROD_W'(DIV_RECIP);
    prod   = PROD_W'(chan) * factor;
    return prod[DIV_SHIFT +: CHAN_W];
  endfunction

endpackage

`default_nettype wire

@@ hdl/weighted_window_blur_filter.sv @@
// top level of the weighted window blur filter
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  s_tdata = red, green, blue; s_tuser = mode
//   m_*       out  m_tvalid/m_tready  m_tdata = red, green, blue; m_tlast = frame_done
//   cfg_*     in   cfg_wr_en          cfg_wr_data = image_size
//
// one item is accepted per cycle while s_tready is high; a result passes the window
// capture and tap product registers, then its tap sum is loaded into m_*
// the two line buffers are read and written once per transfer that advances the frame
// (an ignored early flush does not) at a shared pointer
// rst clears counters, pipeline valids and sets image_size to 32; no clearing pass
// a stall on m_tready backs up through the pipeline and holds s_tready low only
// once all three stages are full
`default_nettype none

module weighted_window_blur_filter
  import wbf_pkg::*;
#(
  parameter int MAX_SIZE = MAX_SIZE_DEFAULT
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     s_tvalid,
  output logic                    s_tready,
  input  wire  [PIX_W-1:0]        s_tdata,   // in_red, in_green, in_blue
  input  wire                     s_tuser,   // mode
  output logic                    m_tvalid,
  input  wire                     m_tready,
  output logic [PIX_W-1:0]        m_tdata,   // out_red, out_green, out_blue
  output logic                    m_tlast,
  input  wire                     cfg_wr_en,
  input  wire  [IMAGE_SIZE_W-1:0] cfg_wr_data
);

  localparam int SIZE_W     = $clog2(MAX_SIZE + 1);
  localparam int EXT_W      = SIZE_W + 1;
  localparam int CNT_W      = 2 * SIZE_W + 1;
  localparam int LINE_DEPTH = MAX_SIZE - 1;
  localparam int PTR_W      = $clog2(LINE_DEPTH);

  // decoded configuration
  logic [SIZE_W-1:0] size_eff;
  logic [CNT_W-1:0]  npix;
  logic [CNT_W-1:0]  lag;
  logic [CNT_W-1:0]  last_t;
  logic              line_bypass;
  logic [PTR_W-1:0]  line_last;

  logic [IMAGE_SIZE_W-1:0] size_src;
  logic [SIZE_W-1:0]       size_dec;
  logic [CNT_W-1:0]        npix_dec;
  logic [CNT_W-1:0]        lag_dec;

  // frame position
  logic [CNT_W-1:0]  t;
  logic [SIZE_W-1:0] out_row;
  logic [SIZE_W-1:0] out_col;

  // stream control
  logic in_xfer;
  logic slot;
  logic emit;
  logic last;

  // pipeline
  logic rdy1;
  logic rdy2;
  logic rdy3;
  logic v1;
  logic v2;
  logic last1;
  logic last2;
  tap_vec_t taps;
  tap_vec_t taps_masked;
  tap_vec_t taps1;
  chan_t    prod2 [TAP_N][CHAN_N];
  logic [TAP_N-1:0] tap_in;
  logic row_ok1;
  logic row_ok2;
  logic col_ok1;
  logic col_ok2;
  logic [PIX_W-1:0] sum_next;

  // size decode, from the write data or the reset value
  always_comb begin
    size_src = rst ? IMAGE_SIZE_W'(IMAGE_SIZE_RESET) : cfg_wr_data;
    if (size_src == '0) begin
      size_dec = SIZE_W'(1);
    end else if (int'(size_src) > MAX_SIZE) begin
      size_dec = SIZE_W'(MAX_SIZE);
    end else begin
      size_dec = SIZE_W'(size_src);
    end
    npix_dec = CNT_W'(size_dec) * CNT_W'(size_dec);
    lag_dec  = (CNT_W'(size_dec) << 1) + CNT_W'(2);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      size_eff    <= size_dec;
      npix        <= npix_dec;
      lag         <= lag_dec;
      last_t      <= npix_dec + lag_dec - CNT_W'(1);
      line_bypass <= (size_dec == SIZE_W'(1));
      line_last   <= PTR_W'(size_dec - SIZE_W'(2));
    end
  end

  // which transfers move the stream and which give a result
  assign in_xfer = s_tvalid && s_tready;
  assign slot    = in_xfer && !((t < npix) && (s_tuser == MODE_FLUSH));
  assign emit    = slot && (t >= lag);
  assign last    = emit && (t == last_t);

  // frame counters
  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      t       <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (slot) begin
      if (last) begin
        t       <= '0;
        out_row <= '0;
        out_col <= '0;
      end else begin
        t <= t + CNT_W'(1);
        if (emit) begin
          if (EXT_W'(out_col) + EXT_W'(1) == EXT_W'(size_eff)) begin
            out_col <= '0;
            out_row <= out_row + SIZE_W'(1);
          end else begin
            out_col <= out_col + SIZE_W'(1);
          end
        end
      end
    end
  end

  wbf_window #(
    .MAX_SIZE (MAX_SIZE)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .shift_en    (slot),
    .restart     (cfg_wr_en),
    .line_bypass (line_bypass),
    .line_last   (line_last),
    .pix_in      (s_tdata),
    .taps        (taps)
  );

  // taps that fall outside the image count as zero
  assign row_ok1 = EXT_W'(out_row) + EXT_W'(1) < EXT_W'(size_eff);
  assign row_ok2 = EXT_W'(out_row) + EXT_W'(2) < EXT_W'(size_eff);
  assign col_ok1 = EXT_W'(out_col) + EXT_W'(1) < EXT_W'(size_eff);
  assign col_ok2 = EXT_W'(out_col) + EXT_W'(2) < EXT_W'(size_eff);

  always_comb begin
    tap_in         = '0;
    tap_in[TAP_00] = 1'b1;
    tap_in[TAP_01] = col_ok1;
    tap_in[TAP_10] = row_ok1;
    tap_in[TAP_11] = row_ok1 && col_ok1;
    tap_in[TAP_12] = row_ok1 && col_ok2;
    tap_in[TAP_21] = row_ok2 && col_ok1;
    tap_in[TAP_22] = row_ok2 && col_ok2;
    for (int k = 0; k < TAP_N; k++) begin
      taps_masked[k] = tap_in[k] ? taps[k] : '0;
    end
  end

  // stage readiness, filled from the output back
  assign rdy3     = !m_tvalid || m_tready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  // stage one: capture the window
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      taps1 <= taps_masked;
      last1 <= last;
    end
  end

  // stage two: scaled taps per channel
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      last2 <= last1;
      for (int k = 0; k < TAP_N; k++) begin
        for (int c = 0; c < CHAN_N; c++) begin
          prod2[k][c] <= tap_scale(taps1[k][c*CHAN_W +: CHAN_W], TAP_WEIGHT[k]);
        end
      end
    end
  end

  // stage three: channel sums modulo 2^16
  always_comb begin
    sum_next = '0;
    for (int c = 0; c < CHAN_N; c++) begin
      for (int k = 0; k < TAP_N; k++) begin
        sum_next[c*CHAN_W +: CHAN_W] = sum_next[c*CHAN_W +: CHAN_W] + prod2[k][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rdy3) begin
      m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      m_tdata <= sum_next;
      m_tlast <= last2;
    end
  end

endmodule

`default_nettype wire

@@ hdl/wbf_window.sv @@
// line buffers and window registers that present the seven stencil taps
`default_nettype none

module wbf_window
  import wbf_pkg::*;
#(
  parameter int MAX_SIZE = MAX_SIZE_DEFAULT
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   shift_en,
  input  wire                                   restart,
  input  wire                                   line_bypass,
  input  wire  [$clog2(MAX_SIZE - 1)-1:0]       line_last,
  input  wire  pixel_t                          pix_in,
  output tap_vec_t                              taps
);

  localparam int LINE_DEPTH = MAX_SIZE - 1;
  localparam int PTR_W      = $clog2(LINE_DEPTH);

  pixel_t mem_a [LINE_DEPTH];
  pixel_t mem_b [LINE_DEPTH];

  logic [PTR_W-1:0] ptr;
  pixel_t rd_a_mem;
  pixel_t rd_b_mem;
  pixel_t rd_a;
  pixel_t rd_b;
  pixel_t r1;
  pixel_t a1;
  pixel_t a2;
  pixel_t b1;
  pixel_t b2;

  // one-pixel lines need no memory delay
  assign rd_a = line_bypass ? r1 : rd_a_mem;
  assign rd_b = line_bypass ? a1 : rd_b_mem;

  // circular pointer shared by both lines
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      ptr <= '0;
    end else if (shift_en && !line_bypass) begin
      if (ptr == line_last) begin
        ptr <= '0;
      end else begin
        ptr <= ptr + PTR_W'(1);
      end
    end
  end

  // first line: read old entry, then overwrite with the newest pixel
  always_ff @(posedge clk) begin
    if (shift_en) begin
      rd_a_mem  <= mem_a[ptr];
      mem_a[ptr] <= pix_in;
    end
  end

  // second line fed from the first line's output
  always_ff @(posedge clk) begin
    if (shift_en) begin
      rd_b_mem  <= mem_b[ptr];
      mem_b[ptr] <= rd_a;
    end
  end

  // short shift registers behind each line
  always_ff @(posedge clk) begin
    if (shift_en) begin
      r1 <= pix_in;
      a1 <= rd_a;
      a2 <= a1;
      b1 <= rd_b;
      b2 <= b1;
    end
  end

  // taps relative to the newest pixel
  always_comb begin
    taps         = '0;
    taps[TAP_22] = pix_in;
    taps[TAP_21] = r1;
    taps[TAP_12] = rd_a;
    taps[TAP_11] = a1;
    taps[TAP_10] = a2;
    taps[TAP_01] = b1;
    taps[TAP_00] = b2;
  end

endmodule

`default_nettype wire

@@ hdl/wbf_checker.sv @@
// port-level checks for the weighted window blur filter and their binding
`default_nettype none

module wbf_checker
  import wbf_pkg::*;
(
  input wire             clk,
  input wire             rst,
  input wire             s_tready,
  input wire             m_tvalid,
  input wire             m_tready,
  input wire [PIX_W-1:0] m_tdata,
  input wire             m_tlast
);

  // a waiting result is not withdrawn
  a_out_hold_valid: assert property (
    @(posedge clk) disable iff (rst) m_tvalid && !m_tready |=> m_tvalid
  ) else $error("result withdrawn while stalled");

  // a waiting result keeps its payload
  a_out_hold_data: assert property (
    @(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast)
  ) else $error("result payload changed while stalled");

  // input backs up only when the output is full and stalled
  a_ready_only_on_stall: assert property (
    @(posedge clk) disable iff (rst) !s_tready |-> m_tvalid && !m_tready
  ) else $error("input stalled without a stalled result");

  // reset empties the pipeline
  a_reset_empty: assert property (
    @(posedge clk) rst |=> !m_tvalid
  ) else $error("result present right after reset");

endmodule

bind weighted_window_blur_filter wbf_checker u_wbf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
